@@ hw/rtl/ssmid_pkg.sv @@
package ssmid_pkg;

    localparam int KEY_W        = 16;
    localparam int OP_W         = 2;
    localparam int OCC_W        = 9;
    localparam int CAPACITY_DEF = 256;
    localparam int FOLD_W       = 16;

    localparam logic [OP_W-1:0] OP_MEMBER = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctrl_t;

    // number of or-fold passes needed to bring n flags down to one
    function automatic int num_folds(input int n);
        int w;
        int f;
        w = n;
        f = 0;
        while (w > 1)
        begin
            w = (w + FOLD_W - 1) / FOLD_W;
            f = f + 1;
        end
        if (f < 1)
        begin
            f = 1;
        end
        return f;
    endfunction

endpackage

@@ hw/rtl/ssmid_cell.sv @@
module ssmid_cell
    import ssmid_pkg::*;
#(
    parameter int CW  = 9,
    parameter int IDX = 0
)
(
    input  logic             clk,
    input  logic [KEY_W-1:0] key,
    input  logic [CW-1:0]    count,
    input  cell_ctrl_t       ctrl,
    input  logic             prev_less,
    input  logic [KEY_W-1:0] prev_key,
    input  logic [KEY_W-1:0] next_key,
    output logic             less,
    output logic             match,
    output logic [KEY_W-1:0] key_q
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             in_use;

    assign in_use = CW'(IDX) < count;
    assign less   = in_use && (key_reg < key);
    assign match  = in_use && (key_reg == key);
    assign key_q  = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.ins && !less)
        begin
            key_next = prev_less ? key : prev_key;
        end
        else if (ctrl.del && !less)
        begin
            key_next = next_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

@@ hw/rtl/ssmid_or_fold.sv @@
module ssmid_or_fold
    import ssmid_pkg::*;
#(
    parameter int N = CAPACITY_DEF
)
(
    input  logic         clk,
    input  logic         load,
    input  logic         step,
    input  logic [N-1:0] vec_in,
    output logic         any
);

    localparam int GROUPS = (N + FOLD_W - 1) / FOLD_W;
    localparam int PW     = GROUPS * FOLD_W;

    logic [PW-1:0] v_reg;
    logic [PW-1:0] v_next;
    logic [PW-1:0] load_vec;
    logic [PW-1:0] fold_vec;

    always_comb
    begin
        load_vec         = '0;
        load_vec[N-1:0]  = vec_in;
        fold_vec         = '0;
        for (int j = 0; j < GROUPS; j++)
        begin
            fold_vec[j] = |v_reg[j*FOLD_W +: FOLD_W];
        end
        v_next = v_reg;
        if (load)
        begin
            v_next = load_vec;
        end
        else if (step)
        begin
            v_next = fold_vec;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    assign any = v_reg[0];

endmodule

@@ hw/rtl/sorted_set_member_insert_delete.sv @@
// Sorted set of distinct 16-bit keys held in a row of CAPACITY cells, lowest key in cell 0.
// Each s transfer carries an opcode (member, insert, delete) and a key; each one yields a
// single m transfer with success, store_full and the occupancy after the operation. In an
// operation every cell first compares its key with the broadcast key and the per-cell
// match flags are loaded into the or-fold; 16-to-1 or-fold passes then gather those flags;
// last, the cells whose key is not below the broadcast key shift toward their neighbor for
// an insert or delete, a step that waits while an earlier result is still held on the m
// side. A new transfer is taken while a finished result still waits on the m side.
module sorted_set_member_insert_delete
    import ssmid_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // opcode[1:0], key[17:2], zero[23:18]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // success[0], store_full[1], occupancy[10:2], zero[15:11]
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int FOLDS = num_folds(CAPACITY);
    localparam int FCW   = (FOLDS > 1) ? $clog2(FOLDS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FOLD,
        ST_APPLY
    } state_t;

    state_t           state_reg;
    logic [CW-1:0]    count_reg;
    logic [FCW-1:0]   fold_cnt_reg;
    logic [OP_W-1:0]  opcode_reg;
    logic [KEY_W-1:0] key_reg;
    logic             m_tvalid_reg;
    logic             success_reg;
    logic             full_reg;
    logic [OCC_W-1:0] occ_reg;

    logic [KEY_W-1:0]   cell_key [CAPACITY];
    logic [CAPACITY-1:0] less_v;
    logic [CAPACITY-1:0] match_v;
    cell_ctrl_t         cell_ctrl;

    logic             found;
    logic             is_full;
    logic             ins_ok;
    logic             full_fail;
    logic             del_ok;
    logic             success;
    logic             fire;
    logic [CW-1:0]    count_next;
    logic [CW+OCC_W-1:0] occ_ext;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, occ_reg, full_reg, success_reg};

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic             p_less;
            logic [KEY_W-1:0] p_key;
            logic [KEY_W-1:0] n_key;
            if (i == 0)
            begin : g_first
                assign p_less = 1'b1;
                assign p_key  = key_reg;
            end
            else
            begin : g_mid
                assign p_less = less_v[i-1];
                assign p_key  = cell_key[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign n_key = cell_key[i];
            end
            else
            begin : g_inner
                assign n_key = cell_key[i+1];
            end
            ssmid_cell #(
                .CW  (CW),
                .IDX (i)
            ) u_cell (
                .clk       (clk),
                .key       (key_reg),
                .count     (count_reg),
                .ctrl      (cell_ctrl),
                .prev_less (p_less),
                .prev_key  (p_key),
                .next_key  (n_key),
                .less      (less_v[i]),
                .match     (match_v[i]),
                .key_q     (cell_key[i])
            );
        end
    endgenerate

    ssmid_or_fold #(
        .N (CAPACITY)
    ) u_or_fold (
        .clk    (clk),
        .load   (state_reg == ST_LOAD),
        .step   (state_reg == ST_FOLD),
        .vec_in (match_v),
        .any    (found)
    );

    always_comb
    begin
        is_full   = (count_reg == CW'(CAPACITY));
        ins_ok    = (opcode_reg == OP_INSERT) && !found && !is_full;
        full_fail = (opcode_reg == OP_INSERT) && !found && is_full;
        del_ok    = (opcode_reg == OP_DELETE) && found;
        success   = ((opcode_reg == OP_MEMBER) && found) || ins_ok || del_ok;
        fire      = (state_reg == ST_APPLY) && (!m_tvalid_reg || m_tready);
        cell_ctrl.ins = fire && ins_ok;
        cell_ctrl.del = fire && del_ok;
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (del_ok)
        begin
            count_next = count_reg - CW'(1);
        end
        occ_ext = {{OCC_W{1'b0}}, count_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            fold_cnt_reg <= '0;
            opcode_reg   <= OP_MEMBER;
            key_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            success_reg  <= 1'b0;
            full_reg     <= 1'b0;
            occ_reg      <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && !fire)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        opcode_reg <= s_tdata[1:0];
                        key_reg    <= s_tdata[17:2];
                        state_reg  <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    fold_cnt_reg <= FCW'(FOLDS - 1);
                    state_reg    <= ST_FOLD;
                end
                ST_FOLD:
                begin
                    if (fold_cnt_reg == '0)
                    begin
                        state_reg <= ST_APPLY;
                    end
                    else
                    begin
                        fold_cnt_reg <= fold_cnt_reg - FCW'(1);
                    end
                end
                ST_APPLY:
                begin
                    if (fire)
                    begin
                        count_reg    <= count_next;
                        success_reg  <= success;
                        full_reg     <= full_fail;
                        occ_reg      <= occ_ext[OCC_W-1:0];
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
